// ===== hw/rtl/wamm_pkg.sv =====
// Package for the windowed average / min-max tracker.
// Holds the input and result item types shared by the core and its users.
// No dependencies.
package wamm_pkg;

  typedef struct packed {
    logic signed [15:0] sample_x;
    logic signed [15:0] sample_y;
    logic signed [15:0] sample_z;
    logic               snapshot_request;
    logic        [3:0]  client;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] mean_x;
    logic signed [23:0] mean_y;
    logic signed [23:0] mean_z;
    logic               snapshot_valid;
    logic signed [15:0] peak_x;
    logic signed [15:0] peak_y;
    logic signed [15:0] peak_z;
    logic signed [15:0] trough_x;
    logic signed [15:0] trough_y;
    logic signed [15:0] trough_z;
  } out_item_t;

  localparam int unsigned AXES = 3;

endpackage

// ===== hw/rtl/windowed_average_min_max_tracker_core.sv =====
// Windowed average with client min/max trackers, top level.
// Depends on wamm_pkg for the item types.
//
// Channel   Direction  Ports                                  Content
// in        input      in_valid, in_ready, in_data            one three-axis sample
// out       output     out_valid, out_ready, out_data         window means and snapshot
// cfg       APB        psel, penable, pwrite, paddr, pwdata,  window_length at 0x0
//                      prdata, pready
//
// Each item goes through the update state, the load and divide states for each axis in
// turn, and the finish state; the means come from the shared restoring divider, which
// produces one quotient bit per cycle. The next item is taken only once the sequencer is
// back in idle. The tracker sweep, one client slot per cycle, runs under the divide.
// Reset (rst_n low, synchronous) clears the window, the sums and the seeded flag and sets
// window_length to 16. in_ready is high only while the sequencer is idle; a result stays in
// the output register while out_ready is low, and the next result waits in the finish state.
module windowed_average_min_max_tracker_core #(
  parameter int WINDOW_DEPTH = 64,
  parameter int CLIENT_SLOTS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  wamm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output wamm_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // Widths that follow from the window depth and the slot count.
  localparam int LW = $clog2(WINDOW_DEPTH + 1);          // fill count and length
  localparam int IW = $clog2(WINDOW_DEPTH);              // ring index
  localparam int SW = 16 + $clog2(WINDOW_DEPTH);         // signed running sum
  localparam int DW = SW + 8;                            // dividend magnitude
  localparam int BW = $clog2(DW + 1);                    // divide step counter
  localparam int CW = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
  localparam int KW = $clog2(CLIENT_SLOTS + 1);
  localparam logic [LW-1:0] DEPTH_L = LW'(WINDOW_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_LD   = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [6:0]          wlen_r, wlen_nxt;
  logic [SW-1:0]       sum_r [3];
  logic [SW-1:0]       sum_nxt [3];
  logic [LW-1:0]       fill_r, fill_nxt;
  logic [IW-1:0]       oldest_r, oldest_nxt;
  logic                seeded_r, seeded_nxt;
  wamm_pkg::in_item_t  in_r;
  logic                snap_r;
  logic [47:0]         win_mem [WINDOW_DEPTH];
  logic [47:0]         rd_q;
  logic [47:0]         slot_max_r [CLIENT_SLOTS];
  logic [47:0]         slot_min_r [CLIENT_SLOTS];
  logic [KW-1:0]       k_r, k_nxt;
  logic                sweep_r, sweep_nxt;
  logic [47:0]         peak_r, trough_r;
  logic [1:0]          axis_r, axis_nxt;
  logic [BW-1:0]       step_r, step_nxt;
  logic [DW-1:0]       num_r, num_nxt;
  logic [LW:0]         rem_r, rem_nxt;
  logic                neg_r, neg_nxt;
  logic [23:0]         mean_r [3];
  logic                out_valid_r, out_valid_nxt;
  wamm_pkg::out_item_t out_r;

  logic                cfg_wr, in_fire, out_load;
  logic [LW-1:0]       eff_len;
  logic                full_c;
  logic [IW-1:0]       pos_c;
  logic [47:0]         s_bus;
  logic [CW-1:0]       k_idx;
  logic [47:0]         nmax, nmin;
  logic                hit;
  logic [LW:0]         rem_sh;
  logic                qbit;
  logic [SW-1:0]       sel_sum, sel_mag;
  logic [DW-1:0]       q_signed;
  logic [LW:0]         old_inc;

  assign pready   = 1'b1;
  assign prdata   = {25'd0, wlen_r};
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Window length 0 behaves as 1, lengths past the ring depth as the depth.
  always_comb begin
    if (wlen_r == 7'd0) begin
      eff_len = LW'(1);
    end else if (32'(wlen_r) > 32'(WINDOW_DEPTH)) begin
      eff_len = DEPTH_L;
    end else begin
      eff_len = LW'(wlen_r);
    end
  end

  // The length only changes through a write that clears the window, so the oldest
  // index is always below the length and is the slot to replace once full.
  assign full_c  = (fill_r >= eff_len);
  assign pos_c   = full_c ? oldest_r : fill_r[IW-1:0];
  assign s_bus   = {in_r.sample_z, in_r.sample_y, in_r.sample_x};
  assign old_inc = {1'b0, LW'(oldest_r)} + (LW+1)'(1);

  // Ring memory: written in the update state, read every cycle at the current slot.
  always_ff @(posedge clk) begin
    if (state_r == S_UPD) begin
      win_mem[pos_c] <= s_bus;
    end
    rd_q <= win_mem[pos_c];
  end

  // Tracker sweep: one client slot per cycle, all three axes at once. Before the first
  // sample the stored extremes are meaningless, so the sample itself stands in for them.
  assign k_idx = k_r[CW-1:0];
  assign hit   = snap_r && (32'(in_r.client) == 32'(k_r));
  always_comb begin
    logic [15:0] sv, om, on;
    for (int a = 0; a < 3; a++) begin
      sv = s_bus[16*a +: 16];
      om = seeded_r ? slot_max_r[k_idx][16*a +: 16] : sv;
      on = seeded_r ? slot_min_r[k_idx][16*a +: 16] : sv;
      nmax[16*a +: 16] = ($signed(sv) > $signed(om)) ? sv : om;
      nmin[16*a +: 16] = ($signed(sv) < $signed(on)) ? sv : on;
    end
  end

  always_ff @(posedge clk) begin
    if (sweep_r) begin
      slot_max_r[k_idx] <= hit ? s_bus : nmax;
      slot_min_r[k_idx] <= hit ? s_bus : nmin;
      if (hit) begin
        peak_r   <= nmax;
        trough_r <= nmin;
      end
    end
  end

  // Divider datapath: magnitude of sum * 256 over the fill count, one bit per step.
  always_comb begin
    case (axis_r)
      2'd0:    sel_sum = sum_r[0];
      2'd1:    sel_sum = sum_r[1];
      default: sel_sum = sum_r[2];
    endcase
  end
  assign sel_mag  = sel_sum[SW-1] ? (~sel_sum + SW'(1)) : sel_sum;
  assign rem_sh   = {rem_r[LW-1:0], num_r[DW-1]};
  assign qbit     = (rem_sh >= {1'b0, fill_r});
  assign q_signed = neg_r ? (~num_r + DW'(1)) : num_r;
  assign out_load = (state_r == S_FIN) && !sweep_r && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt  = state_r;
    wlen_nxt   = wlen_r;
    sum_nxt    = sum_r;
    fill_nxt   = fill_r;
    oldest_nxt = oldest_r;
    seeded_nxt = seeded_r;
    k_nxt      = k_r;
    sweep_nxt  = sweep_r;
    axis_nxt   = axis_r;
    step_nxt   = step_r;
    num_nxt    = num_r;
    rem_nxt    = rem_r;
    neg_nxt    = neg_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (sweep_r) begin
      if (k_r == KW'(CLIENT_SLOTS - 1)) begin
        sweep_nxt  = 1'b0;
        seeded_nxt = 1'b1;
      end else begin
        k_nxt = k_r + KW'(1);
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        for (int a = 0; a < 3; a++) begin
          sum_nxt[a] = sum_r[a] + {{(SW-16){s_bus[16*a+15]}}, s_bus[16*a +: 16]}
                     - (full_c ? {{(SW-16){rd_q[16*a+15]}}, rd_q[16*a +: 16]} : SW'(0));
        end
        if (full_c) begin
          oldest_nxt = (old_inc >= {1'b0, eff_len}) ? IW'(0) : old_inc[IW-1:0];
        end else begin
          fill_nxt = fill_r + LW'(1);
        end
        k_nxt     = '0;
        sweep_nxt = 1'b1;
        axis_nxt  = 2'd0;
        state_nxt = S_LD;
      end
      S_LD: begin
        num_nxt   = {sel_mag, 8'd0};
        rem_nxt   = '0;
        neg_nxt   = sel_sum[SW-1];
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (step_r == BW'(DW)) begin
          if (axis_r == 2'd2) begin
            state_nxt = S_FIN;
          end else begin
            axis_nxt  = axis_r + 2'd1;
            state_nxt = S_LD;
          end
        end else begin
          rem_nxt  = qbit ? (rem_sh - {1'b0, fill_r}) : rem_sh;
          num_nxt  = {num_r[DW-2:0], qbit};
          step_nxt = step_r + BW'(1);
        end
      end
      S_FIN: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Writing the length restarts the window; the trackers keep their contents.
    if (cfg_wr) begin
      wlen_nxt   = pwdata[6:0];
      sum_nxt[0] = '0;
      sum_nxt[1] = '0;
      sum_nxt[2] = '0;
      fill_nxt   = '0;
      oldest_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wlen_r      <= 7'd16;
      sum_r[0]    <= '0;
      sum_r[1]    <= '0;
      sum_r[2]    <= '0;
      fill_r      <= '0;
      oldest_r    <= '0;
      seeded_r    <= 1'b0;
      k_r         <= '0;
      sweep_r     <= 1'b0;
      axis_r      <= 2'd0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wlen_r      <= wlen_nxt;
      sum_r       <= sum_nxt;
      fill_r      <= fill_nxt;
      oldest_r    <= oldest_nxt;
      seeded_r    <= seeded_nxt;
      k_r         <= k_nxt;
      sweep_r     <= sweep_nxt;
      axis_r      <= axis_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
    if (in_fire) begin
      in_r   <= in_data;
      snap_r <= in_data.snapshot_request && (32'(in_data.client) < 32'(CLIENT_SLOTS));
    end
    if ((state_r == S_DIV) && (step_r == BW'(DW))) begin
      mean_r[axis_r] <= q_signed[23:0];
    end
    if (out_load) begin
      out_r.mean_x         <= mean_r[0];
      out_r.mean_y         <= mean_r[1];
      out_r.mean_z         <= mean_r[2];
      out_r.snapshot_valid <= snap_r;
      out_r.peak_x         <= snap_r ? peak_r[15:0]    : 16'd0;
      out_r.peak_y         <= snap_r ? peak_r[31:16]   : 16'd0;
      out_r.peak_z         <= snap_r ? peak_r[47:32]   : 16'd0;
      out_r.trough_x       <= snap_r ? trough_r[15:0]  : 16'd0;
      out_r.trough_y       <= snap_r ? trough_r[31:16] : 16'd0;
      out_r.trough_z       <= snap_r ? trough_r[47:32] : 16'd0;
    end
  end

endmodule
